/* src/bpa_pkg.sv */
`default_nettype none

package bpa_pkg;

    // Map geometry
    localparam int PAGES     = 4096;
    localparam int WORD_BITS = 64;
    localparam int MAX_RUN   = 64;

    localparam int MAP_WORDS = (PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int WADDR_W   = $clog2(MAP_WORDS);
    localparam int PAGE_W    = 12;
    localparam int CNT_W     = 7;
    localparam int RUN_W     = $clog2(MAX_RUN + 1);
    localparam int SPAN_W    = BIT_W + 1;
    localparam int AVAIL_W   = ((RUN_W > SPAN_W) ? RUN_W : SPAN_W) + 1;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [PAGE_W-1:0]    t_page;
    typedef logic [BIT_W-1:0]     t_bit;
    typedef logic [WADDR_W-1:0]   t_waddr;
    typedef logic [RUN_W-1:0]     t_run;
    typedef logic [CNT_W-1:0]     t_count;
    typedef logic [1:0]           t_status;

    // Command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Status codes
    localparam t_status ST_OK           = 2'd0;
    localparam t_status ST_NO_SPACE     = 2'd1;
    localparam t_status ST_BAD_COUNT    = 2'd2;
    localparam t_status ST_ALREADY_FREE = 2'd3;

    // Request to the word scanner
    typedef struct packed {
        t_word  word;
        t_bit   offset;
        logic   limit_en;
        t_bit   limit_bit;
        t_run   run;
        t_count want;
    } t_scan_req;

    // Answer of the word scanner
    typedef struct packed {
        logic               cur_free;
        logic               hit;
        t_bit               pos;
        logic [AVAIL_W-1:0] avail;
        logic               found;
    } t_scan_res;

endpackage

`default_nettype wire

/* src/bpa_ram.sv */
`default_nettype none

module bpa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* src/bpa_scan.sv */
`default_nettype none

module bpa_scan (
    input  wire bpa_pkg::t_scan_req i_req,
    output bpa_pkg::t_scan_res      o_res
);

    import bpa_pkg::*;

    t_word             lim_mask;
    t_word             eff;
    t_word             vec;
    logic              cur_free;
    logic              hit;
    t_bit              pos;
    logic [SPAN_W-1:0] span;
    logic [AVAIL_W-1:0] avail;

    // Bits at or past the limit count as used
    assign lim_mask = i_req.limit_en ? ({WORD_BITS{1'b1}} << i_req.limit_bit) : '0;
    assign eff      = i_req.word | lim_mask;
    assign cur_free = ~eff[i_req.offset];

    // Look for the next bit of the other kind at or above the offset
    assign vec = (cur_free ? eff : ~eff) & ({WORD_BITS{1'b1}} << i_req.offset);

    always_comb begin
        hit = 1'b0;
        pos = '0;
        for (int k = WORD_BITS - 1; k >= 0; k--) begin
            if (vec[k]) begin
                hit = 1'b1;
                pos = t_bit'(k);
            end
        end
    end

    // Free pages seen so far plus the free stretch in this word
    assign span  = hit ? (SPAN_W'(pos) - SPAN_W'(i_req.offset))
                       : (SPAN_W'(WORD_BITS) - SPAN_W'(i_req.offset));
    assign avail = AVAIL_W'(i_req.run) + AVAIL_W'(span);

    assign o_res.cur_free = cur_free;
    assign o_res.hit      = hit;
    assign o_res.pos      = pos;
    assign o_res.avail    = avail;
    assign o_res.found    = cur_free && (avail >= AVAIL_W'(i_req.want));

endmodule

`default_nettype wire

/* src/bitmap_page_allocator_unit.sv */
`default_nettype none

// channel   valid        stall         payload
// -------   -----------  ------------  -----------------------------------------
// request   i_in_valid   o_in_stall    i_command, i_page_count, i_page_index
// result    o_out_valid  i_out_stall   o_status, o_start_page
//
// Free: S_FREE_RD, then S_FREE_WR clears the bit if used. Bad count: straight to S_PUT.
// Allocate: S_FETCH and S_SCAN per word visited (up to MAP_WORDS + 1 in a full pass),
// a rescan per free/used boundary inside a word, and S_SET_RD, S_SET_WR per word the run covers.
// Reset (synchronous, active low) marks every page free at once by clearing
// the per-word valid flags. A request is taken only while idle; a stalled
// result sits in the output register and the next result waits behind it in S_PUT.

module bitmap_page_allocator_unit (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire logic             i_command,
    input  wire bpa_pkg::t_count  i_page_count,
    input  wire bpa_pkg::t_page   i_page_index,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output bpa_pkg::t_status      o_status,
    output bpa_pkg::t_page        o_start_page
);

    import bpa_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_FETCH   = 8'b0000_0010,
        S_SCAN    = 8'b0000_0100,
        S_SET_RD  = 8'b0000_1000,
        S_SET_WR  = 8'b0001_0000,
        S_FREE_RD = 8'b0010_0000,
        S_FREE_WR = 8'b0100_0000,
        S_PUT     = 8'b1000_0000
    } t_state;

    t_state              r_state,      n_state;
    t_count              r_want,       n_want;
    t_page               r_hint,       n_hint;
    t_page               r_pos,        n_pos;
    t_run                r_run,        n_run;
    logic                r_seg_b,      n_seg_b;
    t_page               r_start,      n_start;
    logic                r_set_hi,     n_set_hi;
    logic                r_rd_vld,     n_rd_vld;
    logic [MAP_WORDS-1:0] r_row_valid, n_row_valid;
    t_status             r_res_status, n_res_status;
    t_page               r_res_start,  n_res_start;
    logic                r_out_valid,  n_out_valid;
    t_status             r_out_status, n_out_status;
    t_page               r_out_start,  n_out_start;

    logic   rd_en;
    t_waddr rd_addr;
    logic   wr_en;
    t_waddr wr_addr;
    t_word  wr_data;
    t_word  ram_q;
    t_word  rd_word;

    t_scan_req scan_req;
    t_scan_res scan_res;

    t_waddr                  pos_word;
    t_bit                    pos_bit;
    t_page                   hit_page;
    logic [PAGE_W:0]         next_word_page;
    logic [2*WORD_BITS-1:0]  set_m128;
    t_word                   set_mask;
    t_waddr                  set_addr;

    // Bitmap storage
    bpa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_q)
    );

    // Words never written read as all free
    assign rd_word = r_rd_vld ? ram_q : '0;

    // Word scanner
    assign pos_word = r_pos[PAGE_W-1:BIT_W];
    assign pos_bit  = r_pos[BIT_W-1:0];

    assign scan_req.word      = rd_word;
    assign scan_req.offset    = pos_bit;
    assign scan_req.limit_en  = r_seg_b && (pos_word == r_hint[PAGE_W-1:BIT_W]);
    assign scan_req.limit_bit = r_hint[BIT_W-1:0];
    assign scan_req.run       = r_run;
    assign scan_req.want      = r_want;

    bpa_scan u_scan (
        .i_req (scan_req),
        .o_res (scan_res)
    );

    assign hit_page       = {pos_word, scan_res.pos};
    assign next_word_page = {({1'b0, pos_word} + (WADDR_W + 1)'(1)), {BIT_W{1'b0}}};

    // Run mask over the start word and the one after it
    assign set_m128 = {{WORD_BITS{1'b0}}, ~({WORD_BITS{1'b1}} << r_want)}
                      << r_start[BIT_W-1:0];
    assign set_mask = r_set_hi ? set_m128[2*WORD_BITS-1:WORD_BITS]
                               : set_m128[WORD_BITS-1:0];
    assign set_addr = r_start[PAGE_W-1:BIT_W] + WADDR_W'(r_set_hi);

    assign o_in_stall = (r_state != S_IDLE);

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_want       = r_want;
        n_hint       = r_hint;
        n_pos        = r_pos;
        n_run        = r_run;
        n_seg_b      = r_seg_b;
        n_start      = r_start;
        n_set_hi     = r_set_hi;
        n_rd_vld     = r_rd_vld;
        n_res_status = r_res_status;
        n_res_start  = r_res_start;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_start  = r_out_start;
        rd_en        = 1'b0;
        rd_addr      = pos_word;
        wr_en        = 1'b0;
        wr_addr      = set_addr;
        wr_data      = rd_word | set_mask;

        // result taken downstream
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_command == CMD_FREE) begin
                        n_pos   = i_page_index;
                        n_state = S_FREE_RD;
                    end else if (i_page_count == '0 ||
                                 i_page_count > CNT_W'(MAX_RUN)) begin
                        n_res_status = ST_BAD_COUNT;
                        n_res_start  = '0;
                        n_state      = S_PUT;
                    end else begin
                        n_want  = i_page_count;
                        n_pos   = r_hint;
                        n_run   = '0;
                        n_seg_b = 1'b0;
                        n_state = S_FETCH;
                    end
                end
            end

            S_FETCH: begin
                rd_en   = 1'b1;
                n_state = S_SCAN;
            end

            S_SCAN: begin
                if (scan_res.found) begin
                    n_start  = r_pos - PAGE_W'(r_run);
                    n_hint   = r_pos - PAGE_W'(r_run);
                    n_set_hi = 1'b0;
                    n_state  = S_SET_RD;
                end else if (scan_res.hit) begin
                    // boundary inside this word: keep the data, move on
                    n_run = '0;
                    if (r_seg_b && hit_page >= r_hint) begin
                        n_res_status = ST_NO_SPACE;
                        n_res_start  = '0;
                        n_state      = S_PUT;
                    end else begin
                        n_pos = hit_page;
                    end
                end else begin
                    n_run = scan_res.cur_free ? scan_res.avail[RUN_W-1:0] : '0;
                    if (r_seg_b) begin
                        if (next_word_page >= {1'b0, r_hint}) begin
                            n_res_status = ST_NO_SPACE;
                            n_res_start  = '0;
                            n_state      = S_PUT;
                        end else begin
                            n_pos   = next_word_page[PAGE_W-1:0];
                            n_state = S_FETCH;
                        end
                    end else if (next_word_page[PAGE_W]) begin
                        // end of map: the run restarts at page 0
                        if (r_hint == '0) begin
                            n_res_status = ST_NO_SPACE;
                            n_res_start  = '0;
                            n_state      = S_PUT;
                        end else begin
                            n_seg_b = 1'b1;
                            n_pos   = '0;
                            n_run   = '0;
                            n_state = S_FETCH;
                        end
                    end else begin
                        n_pos   = next_word_page[PAGE_W-1:0];
                        n_state = S_FETCH;
                    end
                end
            end

            S_SET_RD: begin
                rd_en   = 1'b1;
                rd_addr = set_addr;
                n_state = S_SET_WR;
            end

            S_SET_WR: begin
                wr_en = 1'b1;
                if (!r_set_hi && (set_m128[2*WORD_BITS-1:WORD_BITS] != '0)) begin
                    n_set_hi = 1'b1;
                    n_state  = S_SET_RD;
                end else begin
                    n_res_status = ST_OK;
                    n_res_start  = r_start;
                    n_state      = S_PUT;
                end
            end

            S_FREE_RD: begin
                rd_en   = 1'b1;
                n_state = S_FREE_WR;
            end

            S_FREE_WR: begin
                n_res_start = '0;
                wr_addr     = pos_word;
                wr_data     = rd_word & ~(WORD_BITS'(1) << pos_bit);
                if (rd_word[pos_bit]) begin
                    wr_en        = 1'b1;
                    n_res_status = ST_OK;
                end else begin
                    n_res_status = ST_ALREADY_FREE;
                end
                n_state = S_PUT;
            end

            S_PUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_start  = r_res_start;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // read valid flag follows the word being read
        if (rd_en) begin
            n_rd_vld = r_row_valid[rd_addr];
        end
    end

    // Per-word valid flags
    always_comb begin
        n_row_valid = r_row_valid;
        if (wr_en) begin
            n_row_valid[wr_addr] = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hint      <= '0;
            r_rd_vld    <= 1'b0;
            r_row_valid <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hint      <= n_hint;
            r_rd_vld    <= n_rd_vld;
            r_row_valid <= n_row_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and payload registers
    always_ff @(posedge i_clk) begin
        r_want       <= n_want;
        r_pos        <= n_pos;
        r_run        <= n_run;
        r_seg_b      <= n_seg_b;
        r_start      <= n_start;
        r_set_hi     <= n_set_hi;
        r_res_status <= n_res_status;
        r_res_start  <= n_res_start;
        r_out_status <= n_out_status;
        r_out_start  <= n_out_start;
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_start_page = r_out_start;

endmodule

`default_nettype wire
